[rtl/eaf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package eaf_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int FRAC_BITS     = 16;
  localparam int GUARD         = 24;

  localparam int IN_W    = 32;
  localparam int SUM_W   = IN_W + 1;
  localparam int CW      = 60;
  localparam int XM_W    = 58;
  localparam int ZW      = 50;
  localparam int MAG_W   = XM_W;
  localparam int RAD_W   = 33;
  localparam int ANG_W   = 25;
  localparam int GAIN_W  = 32;
  localparam int PROD_W  = 2 * GAIN_W;
  localparam int DEG_W   = 40;
  localparam int ANG_SHIFT = FRAC_BITS - 1;
  localparam int QW      = 26;

  // 1e12 = 2^12 * 5^12: drop the power of two, divide by 5^12
  localparam int DEG_POW2  = 12;
  localparam int PRE_SHIFT = ANG_SHIFT - DEG_POW2;
  localparam int DW        = ZW + PRE_SHIFT + 1;
  localparam int DH_LSB    = 27;
  localparam int RCP_SHIFT = 32;
  localparam int PRD_W     = DW - DH_LSB + RCP_SHIFT;
  localparam int RW        = 30;
  localparam int DIV_LAT   = 5;

  localparam logic [GAIN_W-1:0]   GAIN_Q32   = 32'h9B74EDA8;
  localparam logic signed [ZW-1:0] HALF_TURN = 50'sd180000000000000;
  localparam logic [DEG_W-1:0]    DEG_UNIT   = 40'd1000000000000;
  localparam logic [MAG_W:0]      ROUND_HALF = (MAG_W + 1)'(1) << GUARD;

  localparam logic [RW-1:0]        DIV_D     = RW'(DEG_UNIT >> DEG_POW2);
  localparam logic [DW-1:0]        ROUND_POS = DW'(DIV_D >> 1);
  localparam logic [DW-1:0]        ROUND_NEG = ROUND_POS + (DW'(1) << PRE_SHIFT);
  localparam logic [RCP_SHIFT-1:0] RECIP     =
    RCP_SHIFT'((64'd1 << (DH_LSB + RCP_SHIFT)) / 64'(DIV_D));

  typedef struct packed {
    logic                   zero;
    logic [MAG_W-1:0]       mag;
    logic signed [ZW-1:0]   ang;
  } vec_res_t;

  typedef struct packed {
    logic [RAD_W-1:0] major;
    logic [RAD_W-1:0] minor;
  } rad_t;

  typedef struct packed {
    logic                 circle;
    logic signed [ZW:0]   sum;
    rad_t                 rad;
  } div_in_t;

  typedef struct packed {
    logic            circle;
    logic            neg;
    logic [QW-1:0]   quo;
    rad_t            rad;
  } div_out_t;

  // atan(2^-i) in units of 1e-12 degree
  function automatic logic signed [ZW-1:0] atan_val(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = 50'sd45000000000000;
      1:  v = 50'sd26565051177078;
      2:  v = 50'sd14036243467926;
      3:  v = 50'sd7125016348902;
      4:  v = 50'sd3576334374997;
      5:  v = 50'sd1789910608246;
      6:  v = 50'sd895173710211;
      7:  v = 50'sd447614170861;
      8:  v = 50'sd223810500369;
      9:  v = 50'sd111905677066;
      10: v = 50'sd55952891894;
      11: v = 50'sd27976452617;
      12: v = 50'sd13988227142;
      13: v = 50'sd6994113675;
      14: v = 50'sd3497056851;
      15: v = 50'sd1748528427;
      16: v = 50'sd874264214;
      17: v = 50'sd437132107;
      18: v = 50'sd218566053;
      19: v = 50'sd109283027;
      20: v = 50'sd54641513;
      21: v = 50'sd27320757;
      22: v = 50'sd13660378;
      23: v = 50'sd6830189;
      24: v = 50'sd3415095;
      25: v = 50'sd1707547;
      26: v = 50'sd853774;
      27: v = 50'sd426887;
      28: v = 50'sd213443;
      29: v = 50'sd106722;
      30: v = 50'sd53361;
      31: v = 50'sd26680;
      32: v = 50'sd13340;
      33: v = 50'sd6670;
      34: v = 50'sd3335;
      35: v = 50'sd1668;
      36: v = 50'sd834;
      37: v = 50'sd417;
      38: v = 50'sd208;
      39: v = 50'sd104;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [CW-1:0] scale_in(input logic signed [SUM_W-1:0] a);
    return {{(CW - SUM_W - GUARD){a[SUM_W-1]}}, a, {GUARD{1'b0}}};
  endfunction

endpackage

`default_nettype wire

[rtl/eaf_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface eaf_frame_if import eaf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  u_x;
  logic signed [IN_W-1:0]  u_y;
  logic signed [IN_W-1:0]  v_x;
  logic signed [IN_W-1:0]  v_y;

  modport source (output valid, output u_x, output u_y, output v_x, output v_y,
                  input ready);
  modport sink   (input valid, input u_x, input u_y, input v_x, input v_y,
                  output ready);
endinterface

interface eaf_axes_if import eaf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [RAD_W-1:0]         major_radius;
  logic [RAD_W-1:0]         minor_radius;
  logic signed [ANG_W-1:0]  angle_degrees;

  modport source (output valid, output major_radius, output minor_radius,
                  output angle_degrees, input ready);
  modport sink   (input valid, input major_radius, input minor_radius,
                  input angle_degrees, output ready);
endinterface

`default_nettype wire

[rtl/eaf_vectoring.sv]
`timescale 1ns / 1ps
`default_nettype none

module eaf_vectoring import eaf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  advance,
  input  wire logic                  in_valid,
  input  wire logic signed [CW-1:0]  x_in,
  input  wire logic signed [CW-1:0]  y_in,
  output logic                       out_valid,
  output vec_res_t                   res
);

  logic [CORDIC_STAGES:0]   vld;
  logic [CORDIC_STAGES:0]   zf;
  logic signed [CW-1:0]     xs [CORDIC_STAGES+1];
  logic signed [CW-1:0]     ys [CORDIC_STAGES];
  logic signed [ZW-1:0]     zs [CORDIC_STAGES+1];
  logic signed [CW-1:0]     xn [CORDIC_STAGES];
  logic signed [CW-1:0]     yn [CORDIC_STAGES-1];
  logic signed [ZW-1:0]     zn [CORDIC_STAGES];

  logic                     pvld;
  logic                     pzero;
  logic signed [ZW-1:0]     pz;
  logic [XM_W-1:0]          hp;
  logic [PROD_W-1:0]        lp;

  always_comb begin
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (!ys[i][CW-1]) begin
        xn[i] = xs[i] + (ys[i] >>> i);
        zn[i] = zs[i] + atan_val(i);
      end else begin
        xn[i] = xs[i] - (ys[i] >>> i);
        zn[i] = zs[i] - atan_val(i);
      end
    end
    for (int i = 0; i < CORDIC_STAGES - 1; i++) begin
      if (!ys[i][CW-1]) begin
        yn[i] = ys[i] - (xs[i] >>> i);
      end else begin
        yn[i] = ys[i] + (xs[i] >>> i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      pvld      <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      vld       <= {vld[CORDIC_STAGES-1:0], in_valid};
      pvld      <= vld[CORDIC_STAGES];
      out_valid <= pvld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // fold left half-plane into the right one
      xs[0] <= x_in[CW-1] ? -x_in : x_in;
      ys[0] <= x_in[CW-1] ? -y_in : y_in;
      zs[0] <= !x_in[CW-1] ? '0 : (y_in[CW-1] ? -HALF_TURN : HALF_TURN);
      zf    <= {zf[CORDIC_STAGES-1:0], (x_in == '0) && (y_in == '0)};
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        xs[i+1] <= xn[i];
        zs[i+1] <= zn[i];
      end
      for (int i = 1; i < CORDIC_STAGES; i++) begin
        ys[i] <= yn[i-1];
      end
      hp    <= XM_W'(xs[CORDIC_STAGES][XM_W-1:GAIN_W]) * XM_W'(GAIN_Q32);
      lp    <= PROD_W'(xs[CORDIC_STAGES][GAIN_W-1:0]) * PROD_W'(GAIN_Q32);
      pz    <= zs[CORDIC_STAGES];
      pzero <= zf[CORDIC_STAGES];
      res.mag  <= MAG_W'(hp) + MAG_W'(lp[PROD_W-1:GAIN_W]);
      res.ang  <= pzero ? '0 : pz;
      res.zero <= pzero;
    end
  end

endmodule

`default_nettype wire

[rtl/eaf_angle_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module eaf_angle_div import eaf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     advance,
  input  wire logic     in_valid,
  input  wire div_in_t  din,
  output logic          out_valid,
  output div_out_t      dout
);

  logic [DIV_LAT-1:0]   vld;
  logic [DIV_LAT-1:0]   neg;
  logic [DIV_LAT-1:0]   circ;
  rad_t                 rad [DIV_LAT];
  logic [ZW-1:0]        mag_bits;
  logic [DW-1:0]        dd;
  logic [PRD_W-1:0]     prod;
  logic [RW-1:0]        dlo1;
  logic [RW-1:0]        dlo2;
  logic [QW-1:0]        qe2;
  logic [QW-1:0]        qe3;
  logic [RW-1:0]        qd;
  logic [RW-1:0]        rem;
  logic [QW-1:0]        quo;

  // one's complement here, the missing +1 rides in ROUND_NEG
  assign mag_bits = din.sum[ZW] ? ~din.sum[ZW-1:0] : din.sum[ZW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[DIV_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      neg    <= {neg[DIV_LAT-2:0], din.sum[ZW]};
      circ   <= {circ[DIV_LAT-2:0], din.circle};
      rad[0] <= din.rad;
      for (int j = 1; j < DIV_LAT; j++) begin
        rad[j] <= rad[j-1];
      end
      dd   <= (DW'(mag_bits) << PRE_SHIFT) + (din.sum[ZW] ? ROUND_NEG : ROUND_POS);
      prod <= PRD_W'(dd[DW-1:DH_LSB]) * PRD_W'(RECIP);
      dlo1 <= dd[RW-1:0];
      // estimate is low by at most one
      qe2  <= prod[RCP_SHIFT +: QW];
      qd   <= RW'(prod[RCP_SHIFT +: QW]) * DIV_D;
      dlo2 <= dlo1;
      rem  <= dlo2 - qd;
      qe3  <= qe2;
      quo  <= qe3 + QW'(rem >= DIV_D);
    end
  end

  assign out_valid   = vld[DIV_LAT-1];
  assign dout.circle = circ[DIV_LAT-1];
  assign dout.neg    = neg[DIV_LAT-1];
  assign dout.quo    = quo;
  assign dout.rad    = rad[DIV_LAT-1];

endmodule

`default_nettype wire

[rtl/ellipse_axes_from_frame_core.sv]
// Path: sum registers, CORDIC pipelines, combine register, divider, output register.
// One transaction per cycle while advance is high; two 24-stage CORDIC pipelines feed a
// five-stage reciprocal multiply that converts the angle to degrees.
// frame.ready is high whenever the output register is empty or being taken.
// Reset (rst, synchronous) clears all valid bits; no results are pending after it.
`timescale 1ns / 1ps
`default_nettype none

module ellipse_axes_from_frame_core import eaf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  eaf_frame_if.sink   frame,
  eaf_axes_if.source  axes
);

  logic                     advance;
  logic                     s0_valid;
  logic signed [SUM_W-1:0]  e2;
  logic signed [SUM_W-1:0]  f2;
  logic signed [SUM_W-1:0]  g2;
  logic signed [SUM_W-1:0]  h2;

  logic                     q_valid;
  logic                     r_valid;
  vec_res_t                 q_res;
  vec_res_t                 r_res;

  logic                     c_valid;
  div_in_t                  c_dat;
  logic [MAG_W:0]           rad_sum;
  logic [MAG_W:0]           diff_qr;
  logic [MAG_W:0]           diff_rq;

  logic                     d_valid;
  div_out_t                 d_dat;
  logic [QW-1:0]            sq;

  logic                     out_valid;
  logic [RAD_W-1:0]         major_radius;
  logic [RAD_W-1:0]         minor_radius;
  logic signed [ANG_W-1:0]  angle_degrees;

  assign advance     = !out_valid || axes.ready;
  assign frame.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      c_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s0_valid  <= frame.valid;
      c_valid   <= q_valid && r_valid;
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      e2 <= SUM_W'(frame.u_x) + SUM_W'(frame.v_y);
      f2 <= SUM_W'(frame.u_x) - SUM_W'(frame.v_y);
      g2 <= SUM_W'(frame.u_y) + SUM_W'(frame.v_x);
      h2 <= SUM_W'(frame.u_y) - SUM_W'(frame.v_x);
    end
  end

  eaf_vectoring u_vec_q (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (s0_valid),
    .x_in      (scale_in(e2)),
    .y_in      (scale_in(h2)),
    .out_valid (q_valid),
    .res       (q_res)
  );

  eaf_vectoring u_vec_r (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (s0_valid),
    .x_in      (scale_in(f2)),
    .y_in      (scale_in(g2)),
    .out_valid (r_valid),
    .res       (r_res)
  );

  assign rad_sum = {1'b0, q_res.mag} + {1'b0, r_res.mag} + ROUND_HALF;
  assign diff_qr = {1'b0, q_res.mag} - {1'b0, r_res.mag} + ROUND_HALF;
  assign diff_rq = {1'b0, r_res.mag} - {1'b0, q_res.mag} + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (advance) begin
      c_dat.rad.major <= rad_sum[GUARD+1 +: RAD_W];
      c_dat.rad.minor <= (q_res.mag >= r_res.mag) ? diff_qr[GUARD+1 +: RAD_W]
                                                  : diff_rq[GUARD+1 +: RAD_W];
      c_dat.sum       <= (ZW+1)'($signed(q_res.ang)) + (ZW+1)'($signed(r_res.ang));
      c_dat.circle    <= r_res.zero;
    end
  end

  eaf_angle_div u_div (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (c_valid),
    .din       (c_dat),
    .out_valid (d_valid),
    .dout      (d_dat)
  );

  assign sq = d_dat.neg ? -d_dat.quo : d_dat.quo;

  always_ff @(posedge clk) begin
    if (advance) begin
      major_radius  <= d_dat.rad.major;
      minor_radius  <= d_dat.rad.minor;
      angle_degrees <= d_dat.circle ? '0 : sq[ANG_W-1:0];
    end
  end

  assign axes.valid         = out_valid;
  assign axes.major_radius  = major_radius;
  assign axes.minor_radius  = minor_radius;
  assign axes.angle_degrees = angle_degrees;

endmodule

`default_nettype wire

[rtl/eaf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module eaf_checker import eaf_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               frame_valid,
  input wire logic               frame_ready,
  input wire logic               axes_valid,
  input wire logic               axes_ready,
  input wire logic [RAD_W-1:0]   major_radius,
  input wire logic [RAD_W-1:0]   minor_radius,
  input wire logic [ANG_W-1:0]   angle_degrees
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    axes_valid && !axes_ready |=> axes_valid && $stable(major_radius) &&
      $stable(minor_radius) && $stable(angle_degrees))
    else $error("axes transaction changed while stalled");

  a_radii_order: assert property (@(posedge clk) disable iff (rst)
    axes_valid |-> minor_radius <= major_radius)
    else $error("minor radius exceeds major radius");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    frame_ready == (!axes_valid || axes_ready))
    else $error("frame ready does not follow output register state");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !axes_valid)
    else $error("axes valid after reset");

  a_in_idle: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_ready |=> !axes_valid || !axes_ready || frame_ready)
    else $error("frame stalled while output drains");

endmodule

bind ellipse_axes_from_frame_core eaf_checker u_eaf_checker (
  .clk           (clk),
  .rst           (rst),
  .frame_valid   (frame.valid),
  .frame_ready   (frame.ready),
  .axes_valid    (axes.valid),
  .axes_ready    (axes.ready),
  .major_radius  (axes.major_radius),
  .minor_radius  (axes.minor_radius),
  .angle_degrees (axes.angle_degrees)
);

`default_nettype wire

[tb/ellipse_axes_from_frame_core_test.sv]
`timescale 1ns / 1ps

module ellipse_axes_from_frame_core_test;
  import eaf_pkg::*;

  typedef struct packed {
    logic signed [IN_W-1:0] u_x;
    logic signed [IN_W-1:0] u_y;
    logic signed [IN_W-1:0] v_x;
    logic signed [IN_W-1:0] v_y;
  } frame_t;

  typedef struct packed {
    logic [RAD_W-1:0]        major;
    logic [RAD_W-1:0]        minor;
    logic signed [ANG_W-1:0] angle;
  } axes_t;

  localparam longint unsigned PICO_DEGREE  = 64'd1000000000000;
  localparam longint          HALF_CIRCLE  = 64'sd180000000000000;
  localparam longint unsigned GAIN_FACTOR  = 64'h9B74EDA8;
  localparam int              PHASE_FRAMES = 444;
  localparam int              REPORT_LIMIT = 60;
  localparam int signed       S_MAX        = 32'sh7FFFFFFF;
  localparam int signed       S_MIN        = -32'sh7FFFFFFF - 1;
  localparam int signed       ONE          = 32'sd65536;

  // atan(2^-i), picodegrees
  longint arctan_tab [40] = '{
    64'sd45000000000000, 64'sd26565051177078, 64'sd14036243467926, 64'sd7125016348902,
    64'sd3576334374997, 64'sd1789910608246, 64'sd895173710211, 64'sd447614170861,
    64'sd223810500369, 64'sd111905677066, 64'sd55952891894, 64'sd27976452617,
    64'sd13988227142, 64'sd6994113675, 64'sd3497056851, 64'sd1748528427,
    64'sd874264214, 64'sd437132107, 64'sd218566053, 64'sd109283027,
    64'sd54641513, 64'sd27320757, 64'sd13660378, 64'sd6830189,
    64'sd3415095, 64'sd1707547, 64'sd853774, 64'sd426887,
    64'sd213443, 64'sd106722, 64'sd53361, 64'sd26680,
    64'sd13340, 64'sd6670, 64'sd3335, 64'sd1668,
    64'sd834, 64'sd417, 64'sd208, 64'sd104
  };

  int signed special_vals [8] = '{0, 1, -1, S_MAX, S_MIN, ONE, -ONE, 32'sh40000000};

  logic clk;
  logic rst;

  eaf_frame_if frame ();
  eaf_axes_if  axes ();

  ellipse_axes_from_frame_core u_dut (
    .clk   (clk),
    .rst   (rst),
    .frame (frame),
    .axes  (axes)
  );

  frame_t frame_queue [$];
  axes_t  axes_expected [$];
  frame_t cur_frame;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     frames_accepted = 0;
  int     results_checked = 0;
  int     directed_count = 0;
  int     errors = 0;

  function automatic void to_polar(input longint x0, input longint y0,
                                   output longint unsigned mag, output longint ang);
    longint x, y, z, dx, dy;
    longint unsigned ux, hi, lo;
    x = x0;
    y = y0;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      ang = 0;
      return;
    end
    if (x < 0) begin
      z = (y >= 0) ? HALF_CIRCLE : -HALF_CIRCLE;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 40; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_tab[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_tab[i];
      end
    end
    ux = x;
    hi = ux >> 32;
    lo = ux & 64'hFFFFFFFF;
    mag = hi * GAIN_FACTOR + ((lo * GAIN_FACTOR) >> 32);
    ang = z;
  endfunction

  function automatic axes_t predict_axes(input frame_t f);
    longint e2, f2, g2, h2, zq, zr, s, scale;
    longint unsigned mq, mr, diff, m, whole, rem, mag;
    axes_t a;
    e2 = longint'($signed(f.u_x)) + longint'($signed(f.v_y));
    f2 = longint'($signed(f.u_x)) - longint'($signed(f.v_y));
    g2 = longint'($signed(f.u_y)) + longint'($signed(f.v_x));
    h2 = longint'($signed(f.u_y)) - longint'($signed(f.v_x));
    scale = longint'(1) << GUARD;
    to_polar(e2 * scale, h2 * scale, mq, zq);
    to_polar(f2 * scale, g2 * scale, mr, zr);
    a.major = RAD_W'((mq + mr + (64'd1 << GUARD)) >> (GUARD + 1));
    diff = (mq >= mr) ? (mq - mr) : (mr - mq);
    a.minor = RAD_W'((diff + (64'd1 << GUARD)) >> (GUARD + 1));
    if (f2 == 0 && g2 == 0) begin
      a.angle = '0;
    end else begin
      s = zq + zr;
      m = (s < 0) ? -s : s;
      whole = m / PICO_DEGREE;
      rem = m % PICO_DEGREE;
      mag = (whole << (FRAC_BITS - 1)) +
            ((rem << (FRAC_BITS - 1)) + PICO_DEGREE / 2) / PICO_DEGREE;
      if (s < 0) begin
        mag = -mag;
      end
      a.angle = ANG_W'(mag);
    end
    return a;
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int signed a, b;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    a = $urandom;
    b = $urandom;
    if (mode >= 6 && mode <= 7) begin
      a = a >>> $urandom_range(0, 30);
      b = b >>> $urandom_range(0, 30);
    end
    case (mode)
      0, 1, 2: begin
        f.u_x = $urandom;
        f.u_y = $urandom;
        f.v_x = $urandom;
        f.v_y = $urandom;
      end
      3: begin
        f.u_x = a; f.u_y = b; f.v_x = -b; f.v_y = a;
      end
      4: begin
        f.u_x = a; f.u_y = b; f.v_x = b; f.v_y = -a;
      end
      5: begin
        f.u_x = special_vals[$urandom_range(0, 7)];
        f.u_y = special_vals[$urandom_range(0, 7)];
        f.v_x = special_vals[$urandom_range(0, 7)];
        f.v_y = special_vals[$urandom_range(0, 7)];
      end
      6, 7: begin
        f.u_x = a;
        f.u_y = b;
        f.v_x = -b + $signed($urandom_range(0, 6)) - 3;
        f.v_y = a + $signed($urandom_range(0, 6)) - 3;
      end
      default: begin
        f.u_x = $signed($urandom) >>> $urandom_range(0, 31);
        f.u_y = $signed($urandom) >>> $urandom_range(0, 31);
        f.v_x = $signed($urandom) >>> $urandom_range(0, 31);
        f.v_y = $signed($urandom) >>> $urandom_range(0, 31);
      end
    endcase
    return f;
  endfunction

  task automatic add_frame(input int signed ux, input int signed uy,
                           input int signed vx, input int signed vy);
    frame_t f;
    f.u_x = ux;
    f.u_y = uy;
    f.v_x = vx;
    f.v_y = vy;
    frame_queue.push_back(f);
    directed_count++;
  endtask

  task automatic flag_field(input string field, input logic [63:0] want,
                            input logic [63:0] got);
    errors++;
    if (errors <= REPORT_LIMIT) begin
      $display("%0t %s: expected %h actual %h", $time, field, want, got);
    end
  endtask

  task automatic drain();
    while (frame_queue.size() > 0 || frame.valid || axes_expected.size() > 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    frame.valid = 1'b0;
    frame.u_x = '0;
    frame.u_y = '0;
    frame.v_x = '0;
    frame.v_y = '0;
    axes.ready = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("ellipse_axes_from_frame_core: mismatch");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else begin
      if (frame.valid && frame.ready) begin
        axes_expected.push_back(predict_axes(cur_frame));
        frames_accepted++;
      end
      if (!frame.valid || frame.ready) begin
        if (frame_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_frame = frame_queue.pop_front();
          frame.valid <= 1'b1;
          frame.u_x <= cur_frame.u_x;
          frame.u_y <= cur_frame.u_y;
          frame.v_x <= cur_frame.v_x;
          frame.v_y <= cur_frame.v_y;
        end else begin
          frame.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    axes_t want;
    if (rst) begin
      axes.ready <= 1'b0;
    end else begin
      if (axes.valid && axes.ready) begin
        if (axes_expected.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("%0t unexpected transaction: expected none actual %h %h %h", $time,
                     axes.major_radius, axes.minor_radius, axes.angle_degrees);
          end
        end else begin
          want = axes_expected.pop_front();
          if (axes.major_radius !== want.major) begin
            flag_field("major_radius", want.major, axes.major_radius);
          end
          if (axes.minor_radius !== want.minor) begin
            flag_field("minor_radius", want.minor, axes.minor_radius);
          end
          if (axes.angle_degrees !== want.angle) begin
            flag_field("angle_degrees", want.angle, axes.angle_degrees);
          end
          results_checked++;
        end
      end
      axes.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    send_idle_pct = 30;
    recv_idle_pct = 88;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    add_frame(0, 0, 0, 0);
    add_frame(ONE, 0, 0, ONE);
    add_frame(S_MAX, S_MAX, S_MAX, S_MAX);
    add_frame(S_MIN, S_MIN, S_MIN, S_MIN);
    add_frame(S_MAX, S_MIN, S_MIN, S_MAX);
    add_frame(S_MIN, S_MAX, S_MAX, S_MIN);
    add_frame(S_MAX, 0, 0, S_MIN);
    add_frame(0, ONE, -ONE, 0);
    add_frame(ONE, 0, 0, -ONE);
    add_frame(-ONE, 0, 0, -ONE);
    add_frame(-3 * ONE, 0, 0, -ONE);
    add_frame(-ONE, -2 * ONE, 0, 0);
    add_frame(ONE, 0, ONE, ONE);
    add_frame(1, 0, 0, 0);
    add_frame(-1, -1, -1, -1);
    add_frame(S_MIN, 0, 0, 0);
    add_frame(0, 0, S_MIN, 0);
    add_frame(ONE + 1, 0, 0, ONE);
    add_frame(32'sh100000, 1, 0, 32'sh100000);
    add_frame(0, S_MAX, S_MIN, 0);
    add_frame(3 * ONE, -2 * ONE, 5 * ONE, 7 * ONE);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 88 : 0;
      recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 30 : 0;
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        frame_queue.push_back(random_frame());
      end
      drain();
    end

    repeat (64) @(posedge clk);
    $display("%0d frames accepted (%0d directed), %0d axes results checked, %0d errors",
             frames_accepted, directed_count, results_checked, errors);
    $display("covered zero, circle, extreme, negative-x and random frames under three stall mixes");
    if (errors == 0) begin
      $display("ellipse_axes_from_frame_core: match");
    end else begin
      $display("ellipse_axes_from_frame_core: mismatch");
    end
    $finish;
  end

endmodule
